@@ sv/generational_handle_table_defines.svh @@
// Assertion macros shared by the handle table checkers.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GHT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("generational_handle_table: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("generational_handle_table: assertion failed");

`endif

@@ sv/ght_pkg.sv @@
// Types and constants shared by the generational handle table modules.
package ght_pkg;

   localparam int MODE_W       = 2;
   localparam int HANDLE_W     = 32;
   localparam int OBJ_W        = 48;
   localparam int TYPE_W       = 16;
   localparam int GEN_W        = 16;
   localparam int SLOT_FIELD_W = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   localparam logic [GEN_W-1:0] GEN_RESET = 16'd1;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_LOOKUP,
      KIND_REMOVE,
      KIND_NONE
   } ght_kind_type;

   typedef enum logic {
      BK_ISSUE,
      BK_EXEC
   } ght_back_state_type;

   // A classified request as it travels from the front end to the back end.
   typedef struct packed {
      ght_kind_type            kind;
      logic                    pre_fail;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [GEN_W-1:0]        gen;
      logic [OBJ_W-1:0]        object_ref;
      logic [TYPE_W-1:0]       object_type;
   } ght_op_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [OBJ_W-1:0]  obj;
      logic [TYPE_W-1:0] typ;
      logic [GEN_W-1:0]  gen;
   } ght_entry_type;

endpackage

@@ sv/ght_ifs.sv @@
// Request and response channel interfaces of the handle table.
interface ght_req_if;
   import ght_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [HANDLE_W-1:0] handle;
   logic [OBJ_W-1:0]    object_ref;
   logic [TYPE_W-1:0]   object_type;

   modport source (output valid, output mode, output handle, output object_ref,
                   output object_type, input ready);
   modport sink   (input valid, input mode, input handle, input object_ref,
                   input object_type, output ready);
endinterface

interface ght_rsp_if;
   import ght_pkg::*;
   logic                valid;
   logic                ready;
   logic                success;
   logic [HANDLE_W-1:0] handle_out;
   logic [OBJ_W-1:0]    object_out;

   modport source (output valid, output success, output handle_out, output object_out,
                   input ready);
   modport sink   (input valid, input success, input handle_out, input object_out,
                   output ready);
endinterface

@@ sv/ght_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/ght_front.sv @@
// Front end: accepts requests, decodes the handle and rejects malformed ones.
module ght_front import ght_pkg::*; #(
   parameter int SLOTS = 64
) (
   ght_req_if.sink    req,
   input  logic       queue_full,
   output logic       push,
   output ght_op_type push_op
);
   logic [SLOT_FIELD_W-1:0] low;
   logic                    slot_ok;

   assign low     = req.handle[SLOT_FIELD_W-1:0];
   // The slot field holds slot plus one, so valid values run from 1 to SLOTS.
   assign slot_ok = (low != '0) && ((SLOT_FIELD_W + 1)'(low) <= (SLOT_FIELD_W + 1)'(SLOTS));

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      push_op.gen         = req.handle[HANDLE_W-1:SLOT_FIELD_W];
      push_op.object_ref  = req.object_ref;
      push_op.object_type = req.object_type;
      push_op.slot        = '0;
      push_op.pre_fail    = 1'b1;
      push_op.kind        = KIND_NONE;
      unique case (req.mode)
         MODE_INSERT: begin
            push_op.kind     = KIND_INSERT;
            push_op.pre_fail = (req.object_ref == '0) || (req.object_type == '0);
         end
         MODE_LOOKUP, MODE_REMOVE: begin
            push_op.kind     = (req.mode == MODE_LOOKUP) ? KIND_LOOKUP : KIND_REMOVE;
            push_op.pre_fail = !slot_ok;
            // Out-of-range handles read slot zero; the result is forced to fail.
            push_op.slot     = slot_ok ? (low - SLOT_FIELD_W'(1)) : '0;
         end
         default: begin
            push_op.kind = KIND_NONE;
         end
      endcase
   end
endmodule

@@ sv/ght_queue.sv @@
// Short FIFO of classified requests between the front and back ends.
module ght_queue import ght_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  ght_op_type push_op,
   output logic       full,
   input  logic       pop,
   output logic       not_empty,
   output ght_op_type pop_op
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ght_op_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end
endmodule

@@ sv/ght_back.sv @@
// Back end: reads the entry, checks and updates it, and registers the response.
module ght_back import ght_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  ght_op_type q_op,
   output logic       q_pop,
   ght_rsp_if.source  rsp
);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RAM_W  = $bits(ght_entry_type);

   ght_back_state_type state_ff, state_in;
   ght_op_type         op_ff, op_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [SLOTS-1:0]   genv_ff, genv_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_success_ff, rsp_success_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [OBJ_W-1:0]    rsp_object_ff, rsp_object_in;

   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic              out_free, issue, exec_go, ram_re, ram_we;
   logic [SLOT_W-1:0] ram_raddr;
   logic [RAM_W-1:0]  ram_rdata;
   ght_entry_type     rd, wr;
   logic [GEN_W-1:0]  stored_gen, gen_inc, new_gen;
   logic              type_ok, handle_ok, ok;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      unique case (state_ff)
         BK_ISSUE: state_in = q_valid ? BK_EXEC : BK_ISSUE;
         BK_EXEC:  state_in = out_free ? BK_ISSUE : BK_EXEC;
         default:  state_in = BK_ISSUE;
      endcase
   end

   // State outputs.
   always_comb begin
      issue   = 1'b0;
      exec_go = 1'b0;
      unique case (state_ff)
         BK_ISSUE: issue   = q_valid;
         BK_EXEC:  exec_go = out_free;
         default: begin
            issue   = 1'b0;
            exec_go = 1'b0;
         end
      endcase
   end

   assign q_pop     = issue;
   assign ram_re    = issue;
   assign ram_raddr = (q_op.kind == KIND_INSERT) ? free_idx : q_op.slot[SLOT_W-1:0];

   assign op_in    = issue ? q_op : op_ff;
   assign idx_in   = issue ? ram_raddr : idx_ff;
   assign found_in = issue ? free_found : found_ff;

   ght_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (wr),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd = ght_entry_type'(ram_rdata);

   // Entry check and update.
   always_comb begin
      stored_gen = genv_ff[idx_ff] ? rd.gen : GEN_RESET;
      gen_inc    = stored_gen + GEN_W'(1);
      new_gen    = (gen_inc == '0) ? GEN_RESET : gen_inc;
      type_ok    = (op_ff.object_type == '0) || (rd.typ == op_ff.object_type);
      handle_ok  = !op_ff.pre_fail && used_ff[idx_ff] && (stored_gen == op_ff.gen) && type_ok;

      wr.obj = op_ff.object_ref;
      wr.typ = op_ff.object_type;
      wr.gen = new_gen;

      ok             = 1'b0;
      ram_we         = 1'b0;
      used_in        = used_ff;
      genv_in        = genv_ff;
      rsp_handle_in  = '0;
      rsp_object_in  = '0;
      unique case (op_ff.kind)
         KIND_INSERT: begin
            ok = !op_ff.pre_fail && found_ff;
            if (ok) begin
               rsp_handle_in = {new_gen, SLOT_FIELD_W'(idx_ff) + SLOT_FIELD_W'(1)};
            end
            if (ok && exec_go) begin
               ram_we          = 1'b1;
               used_in[idx_ff] = 1'b1;
               genv_in[idx_ff] = 1'b1;
            end
         end
         KIND_LOOKUP, KIND_REMOVE: begin
            ok = handle_ok;
            if (ok) begin
               rsp_object_in = rd.obj;
            end
            if (ok && exec_go && (op_ff.kind == KIND_REMOVE)) begin
               used_in[idx_ff] = 1'b0;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      rsp_success_in = ok;
      rsp_valid_in   = exec_go ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ISSUE;
         used_ff      <= '0;
         genv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         genv_ff      <= genv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      if (exec_go) begin
         rsp_success_ff <= rsp_success_in;
         rsp_handle_ff  <= rsp_handle_in;
         rsp_object_ff  <= rsp_object_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.success    = rsp_success_ff;
   assign rsp.handle_out = rsp_handle_ff;
   assign rsp.object_out = rsp_object_ff;
endmodule

@@ sv/generational_handle_table.sv @@
// Top level of the generational handle table.
// The table holds SLOTS entries, each with an occupied bit, a 48-bit object reference, a
// 16-bit type tag and a 16-bit generation. A handle carries the generation in bits 31:16
// and the slot number plus one in bits 15:0, so handle zero is never valid. Each request
// on req_bus yields exactly one response on rsp_bus, in order. An insert (mode 0) takes
// the lowest free slot, advances its generation by one (skipping zero), stores the object
// and type and returns the new handle; it fails on a zero object, a zero type or a full
// table. A lookup (mode 1) returns the stored object when the handle names an occupied
// slot with the same generation and the type matches (type zero matches any type). A
// remove (mode 2) makes the same checks, returns the object and frees the slot while
// keeping its generation, so old handles to that slot stay stale. Mode 3 does nothing and
// fails. On any failure the response carries success 0 and zero handle and object fields.
// The front end decodes and classifies each request and places it in a two-entry queue;
// the back end takes one request at a time in two states: an issue state that finds the
// free slot and reads the entry memory, then an exec state that checks the entry, writes
// it back and loads the response register. The exec state waits while a response is
// still held in the response register and rsp_bus is not ready, and the back end takes
// no new request before it leaves that state.
// The response register lets the front end keep accepting requests while a response
// waits, until the queue fills. Occupied and generation-written bits live in flip-flops
// cleared by reset, so the block accepts requests as soon as reset is low.
module generational_handle_table import ght_pkg::*; #(
   parameter int SLOTS = 64
) (
   input logic       clock,
   input logic       reset,
   ght_req_if.sink   req_bus,
   ght_rsp_if.source rsp_bus
);
   logic       q_push, q_full, q_pop, q_not_empty;
   ght_op_type q_push_op, q_pop_op;

   // Decode and classify incoming requests.
   ght_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .req        (req_bus),
      .queue_full (q_full),
      .push       (q_push),
      .push_op    (q_push_op)
   );

   // Decouples request acceptance from entry processing.
   ght_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (q_push_op),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_op    (q_pop_op)
   );

   // Entry memory, occupancy state and the response register.
   ght_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_op    (q_pop_op),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );
endmodule

@@ sv/ght_checker.sv @@
// Port-level checks of the handle table and their attachment to the top level.
`include "generational_handle_table_defines.svh"

module ght_checker import ght_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_success,
   input logic [HANDLE_W-1:0] rsp_handle_out,
   input logic [OBJ_W-1:0]    rsp_object_out
);
   // A stalled response holds.
   `GHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_success) && $stable(rsp_handle_out) && $stable(rsp_object_out))

   // A failed request reports zero handle and object.
   `GHT_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid && !rsp_success, (rsp_handle_out == '0) && (rsp_object_out == '0))

   // A new handle never has a zero generation or slot field and carries no object.
   `GHT_ASSERT_IMPL(a_handle_form, clock, reset, rsp_valid && rsp_success && (rsp_handle_out != '0), (rsp_handle_out[15:0] != '0) && (rsp_handle_out[31:16] != '0) && (rsp_object_out == '0))

   // A successful lookup or remove returns a nonzero object.
   `GHT_ASSERT_IMPL(a_found_obj, clock, reset, rsp_valid && rsp_success && (rsp_handle_out == '0), rsp_object_out != '0)

   // No response is pending right after reset.
   `GHT_ASSERT_IMPL(a_reset_idle, clock, reset, $past(reset), !rsp_valid)
endmodule

bind generational_handle_table ght_checker u_ght_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_success    (rsp_bus.success),
   .rsp_handle_out (rsp_bus.handle_out),
   .rsp_object_out (rsp_bus.object_out)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the generational handle table: directed, random and reuse stimulus.
`timescale 1ns / 100ps

module testbench;
   import ght_pkg::*;

   localparam int TABLE_SLOTS = 64;
   // Mode three is not given a name by the package; it is a no-op that must fail.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   // Cycles without any accepted request or response before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Cycles to wait after the last response so that any stray response shows up.
   localparam int DRAIN_CYCLES = 20;

   // One response as the table is expected to produce it.
   typedef struct {
      logic                success;
      logic [HANDLE_W-1:0] handle_out;
      logic [OBJ_W-1:0]    object_out;
   } table_result_type;

   // A handle that is believed to be live, with the type it was inserted under.
   typedef struct {
      logic [HANDLE_W-1:0] handle;
      logic [TYPE_W-1:0]   otype;
   } live_entry_type;

   // Shadow copy of the table. Each accepted request updates the copy and queues the
   // response that the block owes for it; each response is checked against the oldest one.
   class slot_table_tracker;
      bit                used [TABLE_SLOTS];
      logic [OBJ_W-1:0]  obj  [TABLE_SLOTS];
      logic [GEN_W-1:0]  gen  [TABLE_SLOTS];
      logic [TYPE_W-1:0] typ  [TABLE_SLOTS];
      table_result_type  pending_results [$];

      function new();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            used[i] = 1'b0;
            obj[i]  = '0;
            gen[i]  = GEN_RESET;
            typ[i]  = '0;
         end
      endfunction

      // True when the handle names an occupied slot of the same generation and the type matches or is zero.
      function bit find_live_slot(logic [HANDLE_W-1:0] h, logic [TYPE_W-1:0] t,
                                  output int idx);
         idx = 0;
         if (h[15:0] == 16'd0) return 1'b0;
         idx = int'(h[15:0]) - 1;
         if (idx >= TABLE_SLOTS) return 1'b0;
         if (!used[idx]) return 1'b0;
         if (gen[idx] != h[31:16]) return 1'b0;
         if (t != '0 && typ[idx] != t) return 1'b0;
         return 1'b1;
      endfunction

      function table_result_type note_request(logic [MODE_W-1:0] m, logic [HANDLE_W-1:0] h,
                                              logic [OBJ_W-1:0] o, logic [TYPE_W-1:0] t);
         table_result_type r;
         logic [GEN_W-1:0] g;
         int               idx;
         r.success    = 1'b0;
         r.handle_out = '0;
         r.object_out = '0;
         if (m == MODE_INSERT) begin
            if (o != '0 && t != '0) begin
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (!used[i]) begin
                     // The generation skips zero so that no handle is ever zero.
                     g = gen[i] + 16'd1;
                     if (g == '0) g = GEN_RESET;
                     gen[i]       = g;
                     used[i]      = 1'b1;
                     obj[i]       = o;
                     typ[i]       = t;
                     r.handle_out = {g, 16'(i + 1)};
                     r.success    = 1'b1;
                     break;
                  end
               end
            end
         end else if (m == MODE_LOOKUP || m == MODE_REMOVE) begin
            if (find_live_slot(h, t, idx)) begin
               r.object_out = obj[idx];
               r.success    = 1'b1;
               if (m == MODE_REMOVE) begin
                  used[idx] = 1'b0;
                  obj[idx]  = '0;
                  typ[idx]  = '0;
               end
            end
         end
         pending_results.push_back(r);
         return r;
      endfunction

      // Returns an empty string when the response matches, else a description of it.
      function string check_response(logic s, logic [HANDLE_W-1:0] h, logic [OBJ_W-1:0] o);
         table_result_type want;
         string            msg;
         msg = "";
         if (pending_results.size() == 0)
            return $sformatf("response with no request outstanding: success=%b handle=%h object=%h",
                             s, h, o);
         want = pending_results.pop_front();
         if (s !== want.success)
            msg = {msg, $sformatf(" success=%b want %b", s, want.success)};
         if (h !== want.handle_out)
            msg = {msg, $sformatf(" handle_out=%h want %h", h, want.handle_out)};
         if (o !== want.object_out)
            msg = {msg, $sformatf(" object_out=%h want %h", o, want.object_out)};
         return msg;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ght_req_if req_bus ();
   ght_rsp_if rsp_bus ();

   generational_handle_table #(
      .SLOTS(TABLE_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   slot_table_tracker tracker;

   live_entry_type      live_handles [$];
   logic [HANDLE_W-1:0] retired_handles [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  stall_cycles = 0;
   // While set, neither side inserts idle cycles.
   bit                  quiet_mode = 1'b0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d:%s", cycle_count, msg);
      mismatch_count++;
   endtask

   // The response side stalls with a probability of about nine percent, except in the quiet stretch.
   always @(negedge clock) begin
      rsp_bus.ready <= quiet_mode || ($urandom_range(99) >= 9);
   end

   // Every accepted response is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : response_check
      string msg;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         msg = tracker.check_response(rsp_bus.success, rsp_bus.handle_out,
                                      rsp_bus.object_out);
         if (msg != "") report_mismatch(msg);
      end
   end

   // The watchdog ends a run in which nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired at cycle %0d", cycle_count);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Drives one request at a falling edge, holds it until accepted, and records the
   // expected response. The list of live handles follows the predicted outcome so that
   // later lookups and removes can aim at real entries.
   task automatic send_request(input logic [MODE_W-1:0] m, input logic [HANDLE_W-1:0] h,
                               input logic [OBJ_W-1:0] o, input logic [TYPE_W-1:0] t,
                               output table_result_type r);
      @(negedge clock);
      while (!quiet_mode && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= m;
      req_bus.handle      <= h;
      req_bus.object_ref  <= o;
      req_bus.object_type <= t;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = tracker.note_request(m, h, o, t);
      if (m == MODE_INSERT && r.success) begin
         live_handles.push_back('{handle: r.handle_out, otype: t});
      end
      if (m == MODE_REMOVE && r.success) begin
         for (int i = live_handles.size() - 1; i >= 0; i--) begin
            if (live_handles[i].handle[15:0] == h[15:0]) live_handles.delete(i);
         end
         retired_handles.push_back(h);
         if (retired_handles.size() > 64) void'(retired_handles.pop_front());
      end
   endtask

   // Half of the types come from a small pool so that type checks pass often.
   function automatic logic [TYPE_W-1:0] random_type();
      case ($urandom_range(7))
         0, 1:    return 16'h0001;
         2:       return 16'h0002;
         3:       return 16'hffff;
         default: return TYPE_W'($urandom);
      endcase
   endfunction

   // One random request. Most are inserts and aimed lookups or removes; the rest is noise:
   // stale handles, slot fields out of range or zero and random handles, under any of the four modes.
   task automatic random_request(input int insert_pct);
      int                  roll;
      int                  pick;
      logic [63:0]         wide_obj;
      logic [MODE_W-1:0]   m;
      logic [HANDLE_W-1:0] h;
      logic [OBJ_W-1:0]    o;
      logic [TYPE_W-1:0]   t;
      table_result_type    r;
      roll     = $urandom_range(99);
      wide_obj = {$urandom, $urandom};
      o        = wide_obj[OBJ_W-1:0];
      t        = random_type();
      h        = $urandom;
      if (roll < insert_pct) begin
         m = MODE_INSERT;
         if ($urandom_range(19) == 0) o = '0;
         if ($urandom_range(19) == 0) t = '0;
      end else if (roll < 90) begin
         m = $urandom_range(1) ? MODE_LOOKUP : MODE_REMOVE;
         if (live_handles.size() > 0) begin
            pick = $urandom_range(live_handles.size() - 1);
            h    = live_handles[pick].handle;
            case ($urandom_range(3))
               0, 1:    t = live_handles[pick].otype;
               2:       t = '0;
               default: ; // Keep the random type, usually a mismatch.
            endcase
         end
      end else begin
         m = MODE_W'($urandom_range(3));
         case ($urandom_range(3))
            0: if (retired_handles.size() > 0)
                  h = retired_handles[$urandom_range(retired_handles.size() - 1)];
            1: h[15:0] = 16'($urandom_range(65535, TABLE_SLOTS + 1));
            2: h[15:0] = '0;
            default: ;
         endcase
         if ($urandom_range(3) == 0) t = '0;
      end
      send_request(m, h, o, t, r);
   endtask

   initial begin : stimulus
      table_result_type    r;
      table_result_type    r2;
      logic [HANDLE_W-1:0] h1;
      logic [HANDLE_W-1:0] h2;
      logic [HANDLE_W-1:0] reuse_handle;
      live_entry_type      entry;

      tracker             = new();
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_INSERT;
      req_bus.handle      = '0;
      req_bus.object_ref  = '0;
      req_bus.object_type = '0;
      rsp_bus.ready       = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: rejected inserts, field extremes, every way a handle can fail to
      // match, the unused mode, and reuse of a freed slot under a new generation.
      send_request(MODE_LOOKUP, '0, '0, '0, r);
      send_request(MODE_INSERT, '0, '0, 16'h0005, r);
      send_request(MODE_INSERT, '0, 48'h1, '0, r);
      send_request(MODE_INSERT, '1, '1, '1, r);
      h1 = r.handle_out;
      send_request(MODE_INSERT, '0, 48'h1, 16'h0001, r);
      h2 = r.handle_out;
      send_request(MODE_LOOKUP, h1, '0, '0, r);
      send_request(MODE_LOOKUP, h1, '1, '1, r);
      send_request(MODE_LOOKUP, h1, '0, 16'h0001, r);
      send_request(MODE_LOOKUP, h1 ^ 32'h0001_0000, '0, '0, r);
      send_request(MODE_LOOKUP, {h1[31:16], 16'h0000}, '0, '0, r);
      send_request(MODE_LOOKUP, {h1[31:16], 16'(TABLE_SLOTS + 1)}, '0, '0, r);
      send_request(MODE_LOOKUP, '1, '0, '0, r);
      send_request(MODE_LOOKUP, {16'h0002, 16'h0003}, '0, '0, r);
      send_request(MODE_UNUSED, h1, '1, '1, r);
      send_request(MODE_REMOVE, h2, '0, 16'h0001, r);
      send_request(MODE_REMOVE, h2, '0, 16'h0001, r);
      send_request(MODE_INSERT, '0, 48'h1234_5678_9abc, 16'h8000, r);
      send_request(MODE_LOOKUP, h2, '0, '0, r);
      send_request(MODE_REMOVE, h1, '0, 16'h0001, r);
      send_request(MODE_REMOVE, h1, '0, '0, r);
      send_request(MODE_LOOKUP, h1, '0, '0, r);
      send_request(MODE_REMOVE, '0, '0, '0, r);

      // Insert-heavy random phase: fills the table and keeps hitting the full case.
      repeat (220) random_request(70);

      // Balanced phase with a stretch in which neither side idles.
      for (int i = 0; i < 240; i++) begin
         quiet_mode = (i >= 80 && i < 180);
         random_request(35);
      end
      quiet_mode = 1'b0;

      // Empty the table, then cycle the lowest slot through a few new generations.
      while (live_handles.size() > 0) begin
         entry = live_handles[0];
         send_request(MODE_REMOVE, entry.handle, '0, entry.otype, r);
         if (!r.success) void'(live_handles.pop_front());
      end
      for (int i = 0; i < 8; i++) begin
         send_request(MODE_INSERT, $urandom, 48'(i + 1), 16'h0007, r);
         reuse_handle = r.handle_out;
         send_request(MODE_REMOVE, reuse_handle, '0, '0, r2);
      end
      send_request(MODE_INSERT, '0, '1, 16'h0007, r);
      send_request(MODE_LOOKUP, r.handle_out, '0, 16'h0007, r);

      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
